// ===== design/aivs_pkg.sv =====
// ----------------------------------------------------------------------------
// aivs_pkg
// shared types, register indexes and constants of the adc channel filter
// ----------------------------------------------------------------------------
package aivs_pkg;

    localparam int NUM_CHANNELS = 6;
    localparam int CH_IDX_W     = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

    localparam int CHAN_W   = 3;
    localparam int SAMPLE_W = 12;
    localparam int DATA_W   = 16;
    localparam int REG_IDX_W = 3;

    localparam int DIV_STEPS = DATA_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    typedef logic [CH_IDX_W-1:0]  t_chidx;
    typedef logic [CHAN_W-1:0]    t_chan;
    typedef logic [DATA_W-1:0]    t_data;
    typedef logic [2*DATA_W-1:0]  t_wide;
    typedef logic [REG_IDX_W-1:0] t_reg_idx;

    localparam t_reg_idx REG_COEF_HOLD    = 3'd0;
    localparam t_reg_idx REG_COEF_NEW     = 3'd1;
    localparam t_reg_idx REG_FULL_SCALE   = 3'd2;
    localparam t_reg_idx REG_INTREF_MV    = 3'd3;
    localparam t_reg_idx REG_TYPICAL_VREF = 3'd4;
    localparam t_reg_idx REG_REF_CHANNEL  = 3'd5;

    localparam t_data RST_COEF_HOLD    = 16'd58982;
    localparam t_data RST_COEF_NEW     = 16'd6554;
    localparam t_data RST_FULL_SCALE   = 16'd4095;
    localparam t_data RST_INTREF_MV    = 16'd1210;
    localparam t_data RST_TYPICAL_VREF = 16'd3300;
    localparam t_chan RST_REF_CHANNEL  = 3'd4;

    localparam t_data DATA_MAX = '1;

    typedef struct packed {
        logic load;
        logic read;
        logic mul;
        logic sum;
        logic prod_ld;
        logic prod_cal;
        logic div_start;
        logic div_cal;
        logic vref_wr;
        logic scaled_ld;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic is_cal;
        logic code_zero;
        logic div_done;
        logic out_free;
    } t_sts;

endpackage

// ===== design/aivs_div.sv =====
// ----------------------------------------------------------------------------
// aivs_div
// restoring divider, 32 by 16 bits, one quotient bit a cycle, saturated to 16
// ----------------------------------------------------------------------------
module aivs_div (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  aivs_pkg::t_wide i_num,
    input  aivs_pkg::t_data i_den,
    output logic           o_done,
    output aivs_pkg::t_data o_quot
);
    import aivs_pkg::*;

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    t_data                r_rem;
    t_data                r_quot;
    logic [DATA_W:0]      trial;
    logic                 fits;

    assign trial = {r_rem, r_quot[DATA_W-1]};
    assign fits  = (trial >= {1'b0, i_den});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                if (i_num[2*DATA_W-1:DATA_W] >= i_den) begin
                    r_done <= 1'b1;
                end else begin
                    r_busy <= 1'b1;
                    r_cnt  <= '0;
                end
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= i_num[2*DATA_W-1:DATA_W];
            r_quot <= (i_num[2*DATA_W-1:DATA_W] >= i_den) ? DATA_MAX : i_num[DATA_W-1:0];
        end else if (r_busy) begin
            r_rem  <= fits ? DATA_W'(trial - {1'b0, i_den}) : trial[DATA_W-1:0];
            r_quot <= {r_quot[DATA_W-2:0], fits};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

// ===== design/aivs_datapath.sv =====
// ----------------------------------------------------------------------------
// aivs_datapath
// config registers, filter store, multipliers, divider and output register
// ----------------------------------------------------------------------------
module aivs_datapath (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  aivs_pkg::t_cmd      i_cmd,
    output aivs_pkg::t_sts      o_sts,
    input  logic                i_cfg_we,
    input  aivs_pkg::t_reg_idx  i_cfg_index,
    input  aivs_pkg::t_data     i_cfg_data,
    input  logic                i_action,
    input  aivs_pkg::t_chan     i_channel,
    input  logic [11:0]         i_sample,
    input  logic                i_stall,
    output logic                o_valid,
    output aivs_pkg::t_chan     o_out_channel,
    output aivs_pkg::t_data     o_filtered,
    output aivs_pkg::t_data     o_scaled_mv,
    output aivs_pkg::t_data     o_vref_now,
    output logic                o_cal_error
);
    import aivs_pkg::*;

    t_data r_coef_hold;
    t_data r_coef_new;
    t_data r_full_scale;
    t_data r_intref_mv;
    t_chan r_ref_channel;
    t_data r_vref;

    t_data r_store [NUM_CHANNELS];

    logic                r_action;
    t_chan               r_chan;
    logic [SAMPLE_W-1:0] r_sample;
    logic                r_ok;
    t_data               r_code;
    t_wide               r_p1;
    logic [DATA_W+SAMPLE_W-1:0] r_p2;
    t_wide               r_prod;
    t_data               r_scaled;

    logic        r_o_valid;
    t_chan       r_o_channel;
    t_data       r_o_filtered;
    t_data       r_o_scaled;
    t_data       r_o_vref;
    logic        r_o_err;

    t_chan               sel_ch;
    logic                ch_ok;
    logic [2*DATA_W:0]   acc;
    t_data               new_code;
    t_data               div_den;
    logic                div_done;
    t_data               div_quot;

    assign sel_ch   = r_action ? r_ref_channel : r_chan;
    assign ch_ok    = ({29'd0, sel_ch} < 32'(NUM_CHANNELS));
    assign acc      = (2*DATA_W+1)'(r_p1) + (2*DATA_W+1)'(r_p2);
    assign new_code = acc[2*DATA_W] ? DATA_MAX : acc[2*DATA_W-1:DATA_W];
    assign div_den  = i_cmd.div_cal ? r_code : r_full_scale;

    aivs_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num   (r_prod),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    // config registers and reference voltage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef_hold    <= RST_COEF_HOLD;
            r_coef_new     <= RST_COEF_NEW;
            r_full_scale   <= RST_FULL_SCALE;
            r_intref_mv    <= RST_INTREF_MV;
            r_ref_channel  <= RST_REF_CHANNEL;
            r_vref         <= RST_TYPICAL_VREF;
        end else begin
            if (i_cmd.vref_wr) begin
                r_vref <= div_quot;
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_COEF_HOLD:    r_coef_hold  <= i_cfg_data;
                    REG_COEF_NEW:     r_coef_new   <= i_cfg_data;
                    REG_FULL_SCALE:   r_full_scale <= i_cfg_data;
                    REG_INTREF_MV:    r_intref_mv  <= i_cfg_data;
                    REG_TYPICAL_VREF: r_vref       <= i_cfg_data;
                    REG_REF_CHANNEL:  r_ref_channel <= i_cfg_data[CHAN_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    // per-channel filter store
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_CHANNELS; k++) begin
                r_store[k] <= '0;
            end
        end else if (i_cmd.sum && r_ok) begin
            r_store[t_chidx'(sel_ch)] <= new_code;
        end
    end

    // item datapath
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_action <= i_action;
            r_chan   <= i_channel;
            r_sample <= i_sample;
        end
        if (i_cmd.read) begin
            r_ok   <= ch_ok;
            r_code <= ch_ok ? r_store[t_chidx'(sel_ch)] : '0;
        end
        if (i_cmd.mul) begin
            r_p1 <= r_coef_hold * r_code;
            r_p2 <= r_coef_new * r_sample;
        end
        if (i_cmd.sum && r_ok) begin
            r_code <= new_code;
        end
        if (i_cmd.prod_ld) begin
            r_prod <= i_cmd.prod_cal ? r_intref_mv * r_full_scale : r_code * r_vref;
        end
        if (i_cmd.scaled_ld) begin
            r_scaled <= div_quot;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_o_valid <= 1'b1;
        end else if (!i_stall) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_o_channel  <= sel_ch;
            r_o_filtered <= r_code;
            r_o_scaled   <= r_scaled;
            r_o_vref     <= r_vref;
            r_o_err      <= r_action && (r_code == '0);
        end
    end

    assign o_sts.is_cal    = r_action;
    assign o_sts.code_zero = (r_code == '0);
    assign o_sts.div_done  = div_done;
    assign o_sts.out_free  = !r_o_valid || !i_stall;

    assign o_valid       = r_o_valid;
    assign o_out_channel = r_o_channel;
    assign o_filtered    = r_o_filtered;
    assign o_scaled_mv   = r_o_scaled;
    assign o_vref_now    = r_o_vref;
    assign o_cal_error   = r_o_err;

endmodule

// ===== design/aivs_ctrl.sv =====
// ----------------------------------------------------------------------------
// aivs_ctrl
// sequencer for filter update, calibration and millivolt scaling
// ----------------------------------------------------------------------------
module aivs_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_busy,
    input  aivs_pkg::t_sts i_sts,
    output aivs_pkg::t_cmd o_cmd
);
    import aivs_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_READ,
        S_MUL,
        S_SUM,
        S_CMUL,
        S_CGO,
        S_CWAIT,
        S_SMUL,
        S_SGO,
        S_SWAIT,
        S_OUT
    } t_state;

    t_state r_state;
    t_state n_state;
    t_cmd   cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        cmd     = '0;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    cmd.load = 1'b1;
                    n_state  = S_READ;
                end
            end
            S_READ: begin
                cmd.read = 1'b1;
                n_state  = i_sts.is_cal ? S_CMUL : S_MUL;
            end
            S_MUL: begin
                cmd.mul = 1'b1;
                n_state = S_SUM;
            end
            S_SUM: begin
                cmd.sum = 1'b1;
                n_state = S_SMUL;
            end
            S_CMUL: begin
                cmd.prod_ld  = 1'b1;
                cmd.prod_cal = 1'b1;
                n_state      = i_sts.code_zero ? S_SMUL : S_CGO;
            end
            S_CGO: begin
                cmd.div_start = 1'b1;
                cmd.div_cal   = 1'b1;
                n_state       = S_CWAIT;
            end
            S_CWAIT: begin
                cmd.div_cal = 1'b1;
                if (i_sts.div_done) begin
                    cmd.vref_wr = 1'b1;
                    n_state     = S_SMUL;
                end
            end
            S_SMUL: begin
                cmd.prod_ld = 1'b1;
                n_state     = S_SGO;
            end
            S_SGO: begin
                cmd.div_start = 1'b1;
                n_state       = S_SWAIT;
            end
            S_SWAIT: begin
                if (i_sts.div_done) begin
                    cmd.scaled_ld = 1'b1;
                    n_state       = S_OUT;
                end
            end
            S_OUT: begin
                if (i_sts.out_free) begin
                    cmd.out_load = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_cmd  = cmd;
    assign o_busy = (r_state != S_IDLE);

endmodule

// ===== design/adc_channel_iir_vref_scaler_top.sv =====
// ----------------------------------------------------------------------------
// adc_channel_iir_vref_scaler_top
// sample: filtered, then scaled by a divide; calibrate: vref divide, skipped on a
// zero reading, then scaled; one shared divider, skipped when a quotient saturates
// throughput: one transaction at a time, next taken the cycle after the result
// loads, even while that result waits on a stall
// reset: synchronous active low; store cleared, vref loaded with typical_vref
// ----------------------------------------------------------------------------
module adc_channel_iir_vref_scaler_top (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic               i_action,
    input  aivs_pkg::t_chan    i_channel,
    input  logic [11:0]        i_sample,
    output logic               o_valid,
    input  logic               i_stall,
    output aivs_pkg::t_chan    o_out_channel,
    output aivs_pkg::t_data    o_filtered,
    output aivs_pkg::t_data    o_scaled_mv,
    output aivs_pkg::t_data    o_vref_now,
    output logic               o_cal_error,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  aivs_pkg::t_reg_idx i_cfg_index,
    input  aivs_pkg::t_data    i_cfg_data
);
    import aivs_pkg::*;

    t_cmd cmd;
    t_sts sts;
    logic busy;

    assign o_stall     = busy;
    assign o_cfg_ready = 1'b1;

    aivs_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_busy  (busy),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    aivs_datapath u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_cfg_we      (i_cfg_valid && o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_action      (i_action),
        .i_channel     (i_channel),
        .i_sample      (i_sample),
        .i_stall       (i_stall),
        .o_valid       (o_valid),
        .o_out_channel (o_out_channel),
        .o_filtered    (o_filtered),
        .o_scaled_mv   (o_scaled_mv),
        .o_vref_now    (o_vref_now),
        .o_cal_error   (o_cal_error)
    );

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_stall)
        else $error("block not busy after transaction accepted");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.out_load |-> !(o_valid && i_stall))
        else $error("result register overwritten while stalled");

    a_err_zero_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_cal_error) |-> (o_filtered == '0))
        else $error("calibration error with nonzero reading");

    a_cmd_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({cmd.load, cmd.out_load, cmd.div_start, cmd.vref_wr}))
        else $error("conflicting datapath commands");

endmodule
